### src/cht_pkg.sv
// shared types, codes and widths for the connection handle table
package cht_pkg;

    // default sizes
    localparam int DESCRIPTOR_COUNT_DEF = 64;
    localparam int SIDE_COUNT_DEF       = 32;
    localparam int SLOT_BITS_DEF        = 12;

    // fixed field widths
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 16;
    localparam int SLOT_W   = 12;
    localparam int FLAG_W   = 32;
    localparam int DATA_W   = 64;
    localparam int IN_USER_W  = 4;
    localparam int OUT_USER_W = 3;

    // occupancy bitmap words
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC      = 3'd0,
        OP_ALLOC_FROM = 3'd1,
        OP_BIND       = 3'd2,
        OP_LOOKUP     = 3'd3,
        OP_GET_FLAGS  = 3'd4,
        OP_SET_FLAGS  = 3'd5
    } cht_op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_NONE_FREE = 2'd1,
        STATUS_RANGE     = 2'd2
    } cht_status_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL
    } cht_state_t;

    // controller to datapath
    typedef struct packed {
        logic clr_en;
        logic load;
        logic read;
        logic advance;
        logic finish;
    } cht_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic more;
        logic out_full;
    } cht_sts_t;

endpackage

### src/cht_ram.sv
// generic simple dual port ram with registered read
module cht_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/cht_ctrl.sv
// sequencing state machine for the connection handle table
module cht_ctrl import cht_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  cht_sts_t sts,
    output cht_cmd_t cmd
);

    cht_state_t state_reg;
    cht_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (sts.more)
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_READ;
                end
                else if (!sts.out_full)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

### src/cht_datapath.sv
// request registers, tables, free-entry search and result register
module cht_datapath import cht_pkg::*; #(
    parameter int DESCRIPTOR_COUNT = DESCRIPTOR_COUNT_DEF,
    parameter int SIDE_COUNT       = SIDE_COUNT_DEF,
    parameter int SLOT_BITS        = SLOT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cht_cmd_t              cmd,
    output cht_sts_t              sts,
    input  logic [DATA_W-1:0]     s_tdata,
    input  logic [IN_USER_W-1:0]  s_tuser,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [DATA_W-1:0]     m_tdata,
    output logic [OUT_USER_W-1:0] m_tuser
);

    localparam int DESC_WORDS = (DESCRIPTOR_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int SIDE_WORDS = (SIDE_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int MAX_WORDS  = (DESC_WORDS > SIDE_WORDS) ? DESC_WORDS : SIDE_WORDS;
    localparam int WORD_W     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CAND_W     = WORD_W + BIT_W;
    localparam int BM_DEPTH   = DESC_WORDS + SIDE_WORDS;
    localparam int BM_AW      = $clog2(BM_DEPTH);
    localparam int SLOT_DEPTH = DESCRIPTOR_COUNT + SIDE_COUNT;
    localparam int SLOT_AW    = $clog2(SLOT_DEPTH);
    localparam int FLAG_AW    = $clog2(DESCRIPTOR_COUNT);
    localparam int CLR_LEN    = (BM_DEPTH > DESCRIPTOR_COUNT) ? BM_DEPTH : DESCRIPTOR_COUNT;
    localparam int CLR_W      = $clog2(CLR_LEN);
    localparam int DESC_LAST  = (DESCRIPTOR_COUNT - 1) / WORD_BITS;
    localparam int SIDE_LAST  = (SIDE_COUNT - 1) / WORD_BITS;

    // input beat fields
    cht_op_t             in_op;
    logic                in_side;
    logic [INDEX_W-1:0]  in_idx;
    logic [SLOT_W-1:0]   in_slot;
    logic [FLAG_W-1:0]   in_flag;
    logic                in_ok;
    logic [INDEX_W-1:0]  in_start;
    logic                in_desc_ok;
    logic                in_side_ok;

    // request registers
    cht_op_t              op_reg;
    logic                 pool_side_reg;
    logic                 ok_reg;
    logic [INDEX_W-1:0]   idx_reg;
    logic [SLOT_BITS-1:0] slot_reg;
    logic [FLAG_W-1:0]    flag_reg;
    logic [BIT_W-1:0]     lowbit_reg;
    logic [WORD_W-1:0]    word_reg;
    logic [WORD_W-1:0]    word_next;
    logic                 first_reg;
    logic                 first_next;

    // clearing pass
    logic [CLR_W-1:0] clr_reg;
    logic [CLR_W-1:0] clr_next;

    // memories
    logic                 bm_we;
    logic [BM_AW-1:0]     bm_waddr;
    logic [WORD_BITS-1:0] bm_wdata;
    logic [BM_AW-1:0]     bm_addr;
    logic [WORD_BITS-1:0] bm_rdata;
    logic                 slot_we;
    logic [SLOT_BITS-1:0] slot_wdata;
    logic [SLOT_AW-1:0]   slot_addr;
    logic [SLOT_BITS-1:0] slot_rdata;
    logic                 flag_we;
    logic [FLAG_AW-1:0]   flag_waddr;
    logic [FLAG_W-1:0]    flag_wdata;
    logic [FLAG_AW-1:0]   flag_addr;
    logic [FLAG_W-1:0]    flag_rdata;

    // search
    logic                 scan;
    logic [WORD_BITS-1:0] low_mask;
    logic [WORD_BITS-1:0] free_bits;
    logic                 hit;
    logic [BIT_W-1:0]     pos;
    logic [CAND_W-1:0]    cand;
    logic                 in_count;
    logic                 last_word;
    logic                 found;
    logic                 used_bit;
    logic [INDEX_W-1:0]   entry;
    logic [BIT_W-1:0]     bit_sel;
    logic [WORD_BITS-1:0] bit_onehot;

    // result
    cht_status_t          res_status;
    logic [INDEX_W-1:0]   res_index;
    logic                 res_side;
    logic [SLOT_W-1:0]    res_slot;
    logic [FLAG_W-1:0]    res_flags;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    cht_status_t          out_status_reg;
    logic [INDEX_W-1:0]   out_index_reg;
    logic                 out_side_reg;
    logic [SLOT_W-1:0]    out_slot_reg;
    logic [FLAG_W-1:0]    out_flags_reg;

    // unpack the input beat
    assign in_op   = cht_op_t'(s_tuser[OP_W-1:0]);
    assign in_side = s_tuser[OP_W];
    assign in_idx  = s_tdata[15:0];
    assign in_slot = s_tdata[27:16];
    assign in_flag = s_tdata[59:28];

    assign in_desc_ok = {1'b0, in_idx} < (INDEX_W+1)'(DESCRIPTOR_COUNT);
    assign in_side_ok = {1'b0, in_idx} < (INDEX_W+1)'(SIDE_COUNT);

    // range check and scan start per op
    always_comb
    begin
        in_ok    = 1'b0;
        in_start = in_idx;
        case (in_op)
            OP_ALLOC:
            begin
                in_ok    = 1'b1;
                in_start = in_side ? INDEX_W'(0) : INDEX_W'(1);
            end
            OP_ALLOC_FROM:
            begin
                in_ok = in_desc_ok;
            end
            OP_BIND, OP_LOOKUP:
            begin
                in_ok = in_side ? in_side_ok : in_desc_ok;
            end
            OP_GET_FLAGS, OP_SET_FLAGS:
            begin
                in_ok = !in_side && in_desc_ok;
            end
            default:
            begin
                in_ok = 1'b0;
            end
        endcase
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg        <= in_op;
            pool_side_reg <= in_side && (in_op != OP_ALLOC_FROM);
            ok_reg        <= in_ok;
            idx_reg       <= in_idx;
            slot_reg      <= SLOT_BITS'(in_slot);
            flag_reg      <= in_flag;
            lowbit_reg    <= in_start[BIT_W-1:0];
        end
        word_reg  <= word_next;
        first_reg <= first_next;
    end

    // bitmap word pointer
    always_comb
    begin
        word_next  = word_reg;
        first_next = first_reg;
        if (cmd.load)
        begin
            word_next  = WORD_W'(in_start >> BIT_W);
            first_next = 1'b1;
        end
        else if (cmd.advance)
        begin
            word_next  = word_reg + WORD_W'(1);
            first_next = 1'b0;
        end
    end

    // clearing pass counter
    assign clr_next     = cmd.clr_en ? clr_reg + CLR_W'(1) : clr_reg;
    assign sts.clr_last = (clr_reg == CLR_W'(CLR_LEN - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else
        begin
            clr_reg <= clr_next;
        end
    end

    // lowest free entry in the current bitmap word
    assign scan      = ((op_reg == OP_ALLOC) || (op_reg == OP_ALLOC_FROM)) && ok_reg;
    assign low_mask  = first_reg ? ({WORD_BITS{1'b1}} << lowbit_reg) : {WORD_BITS{1'b1}};
    assign free_bits = ~bm_rdata & low_mask;
    assign hit       = |free_bits;

    always_comb
    begin
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                pos = BIT_W'(i);
            end
        end
    end

    assign cand      = {word_reg, pos};
    assign in_count  = (INDEX_W+1)'(cand) < (pool_side_reg ? (INDEX_W+1)'(SIDE_COUNT)
                                                            : (INDEX_W+1)'(DESCRIPTOR_COUNT));
    assign last_word = word_reg == (pool_side_reg ? WORD_W'(SIDE_LAST) : WORD_W'(DESC_LAST));
    assign found     = hit && in_count;
    assign sts.more  = scan && !hit && !last_word;

    // entry addressing
    assign entry      = scan ? INDEX_W'(cand) : idx_reg;
    assign bit_sel    = scan ? pos : idx_reg[BIT_W-1:0];
    assign bit_onehot = WORD_BITS'(1) << bit_sel;
    assign used_bit   = bm_rdata[idx_reg[BIT_W-1:0]];
    assign bm_addr    = pool_side_reg ? BM_AW'(DESC_WORDS) + BM_AW'(word_reg) : BM_AW'(word_reg);
    assign slot_addr  = pool_side_reg ? SLOT_AW'(DESCRIPTOR_COUNT) + SLOT_AW'(entry)
                                      : SLOT_AW'(entry);
    assign flag_addr  = FLAG_AW'(entry);

    // table writes: clearing pass or request write-back
    always_comb
    begin
        bm_we      = 1'b0;
        bm_waddr   = bm_addr;
        bm_wdata   = '0;
        slot_we    = 1'b0;
        slot_wdata = '0;
        flag_we    = 1'b0;
        flag_waddr = flag_addr;
        flag_wdata = '0;
        if (cmd.clr_en)
        begin
            bm_we      = 32'(clr_reg) < BM_DEPTH;
            bm_waddr   = BM_AW'(clr_reg);
            flag_we    = 32'(clr_reg) < DESCRIPTOR_COUNT;
            flag_waddr = FLAG_AW'(clr_reg);
        end
        else if (cmd.finish && ok_reg)
        begin
            case (op_reg)
                OP_ALLOC, OP_ALLOC_FROM:
                begin
                    bm_we    = found;
                    bm_wdata = bm_rdata | bit_onehot;
                    slot_we  = found;
                    flag_we  = found && (op_reg == OP_ALLOC_FROM);
                end
                OP_BIND:
                begin
                    bm_we      = 1'b1;
                    bm_wdata   = (slot_reg != '0) ? (bm_rdata | bit_onehot)
                                                  : (bm_rdata & ~bit_onehot);
                    slot_we    = 1'b1;
                    slot_wdata = slot_reg;
                end
                OP_SET_FLAGS:
                begin
                    flag_we    = 1'b1;
                    flag_wdata = flag_reg;
                end
                default:
                begin
                    bm_we = 1'b0;
                end
            endcase
        end
    end

    // occupancy bitmap, descriptor words then side words
    cht_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (BM_DEPTH)
    ) u_bitmap (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .re    (cmd.read),
        .raddr (bm_addr),
        .rdata (bm_rdata)
    );

    // slot table, descriptors then side entries
    cht_ram #(
        .WIDTH (SLOT_BITS),
        .DEPTH (SLOT_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_addr),
        .wdata (slot_wdata),
        .re    (cmd.read),
        .raddr (slot_addr),
        .rdata (slot_rdata)
    );

    // descriptor flag words
    cht_ram #(
        .WIDTH (FLAG_W),
        .DEPTH (DESCRIPTOR_COUNT)
    ) u_flags (
        .clk   (clk),
        .we    (flag_we),
        .waddr (flag_waddr),
        .wdata (flag_wdata),
        .re    (cmd.read),
        .raddr (flag_addr),
        .rdata (flag_rdata)
    );

    // result fields
    always_comb
    begin
        res_status = STATUS_RANGE;
        res_index  = '0;
        res_side   = 1'b0;
        res_slot   = '0;
        res_flags  = '0;
        if (ok_reg)
        begin
            case (op_reg)
                OP_ALLOC, OP_ALLOC_FROM:
                begin
                    if (found)
                    begin
                        res_status = STATUS_DONE;
                        res_index  = INDEX_W'(cand);
                        res_side   = pool_side_reg;
                    end
                    else
                    begin
                        res_status = STATUS_NONE_FREE;
                    end
                end
                OP_BIND, OP_SET_FLAGS:
                begin
                    res_status = STATUS_DONE;
                end
                OP_LOOKUP:
                begin
                    res_status = STATUS_DONE;
                    res_slot   = used_bit ? SLOT_W'(slot_rdata) : '0;
                end
                OP_GET_FLAGS:
                begin
                    res_status = STATUS_DONE;
                    res_flags  = flag_rdata;
                end
                default:
                begin
                    res_status = STATUS_RANGE;
                end
            endcase
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_status_reg <= res_status;
            out_index_reg  <= res_index;
            out_side_reg   <= res_side;
            out_slot_reg   <= res_slot;
            out_flags_reg  <= res_flags;
        end
    end

    assign sts.out_full = out_valid_reg && !m_tready;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = {4'b0, out_flags_reg, out_slot_reg, out_index_reg};
    assign m_tuser      = {out_side_reg, out_status_reg};

endmodule

### src/connection_handle_table_top.sv
// top level of the connection handle table
//
//  channel  dir  beat contents
//  s_*      in   tuser: op[2:0] side_pool[3]
//                tdata: entry_index[15:0] slot_number[27:16] flag_word[59:28]
//  m_*      out  tuser: status[1:0] handle_side[2]
//                tdata: handle_index[15:0] slot_out[27:16] flags_out[59:28]
//
// a request passes through accept, table read and evaluate; its result is registered
// as evaluation finishes. allocation reads one 32-entry occupancy word per pass
// through table read and evaluate, until a free entry is found or the pool's last
// word is read. after reset a clearing pass over the bitmap and flag words runs
// before the first request is taken.
// a result waits in the output register while the next request is worked on;
// evaluation holds, and input stays stalled, while that register is still full.
module connection_handle_table_top import cht_pkg::*; #(
    parameter int DESCRIPTOR_COUNT = DESCRIPTOR_COUNT_DEF,
    parameter int SIDE_COUNT       = SIDE_COUNT_DEF,
    parameter int SLOT_BITS        = SLOT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_W-1:0]     s_tdata,   // entry_index, slot_number, flag_word
    input  logic [IN_USER_W-1:0]  s_tuser,   // op, side_pool
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DATA_W-1:0]     m_tdata,   // handle_index, slot_out, flags_out
    output logic [OUT_USER_W-1:0] m_tuser    // status, handle_side
);

    cht_cmd_t cmd;
    cht_sts_t sts;

    // sequencer
    cht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // tables and search
    cht_datapath #(
        .DESCRIPTOR_COUNT (DESCRIPTOR_COUNT),
        .SIDE_COUNT       (SIDE_COUNT),
        .SLOT_BITS        (SLOT_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

### test/connection_handle_checker.sv
// checker for the connection handle table: predicts each request and compares result beats
module connection_handle_checker import cht_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [DATA_W-1:0]     s_tdata,   // entry_index, slot_number, flag_word
    input  logic [IN_USER_W-1:0]  s_tuser,   // op, side_pool
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [DATA_W-1:0]     m_tdata,   // handle_index, slot_out, flags_out
    input  logic [OUT_USER_W-1:0] m_tuser,   // status, handle_side
    output int                    fail_count,
    output int                    outstanding,
    output int                    compared,
    output int                    dry_count,
    output int                    refused_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DESC_N = DESCRIPTOR_COUNT_DEF;
    localparam int SIDE_N = SIDE_COUNT_DEF;
    localparam logic [SLOT_W-1:0] SLOT_MASK = SLOT_W'((64'd1 << SLOT_BITS_DEF) - 1);
    localparam int SLOT_LSB = INDEX_W;
    localparam int FLAG_LSB = INDEX_W + SLOT_W;

    typedef enum logic [1:0] {
        KIND_FREE,
        KIND_RESERVED,
        KIND_BOUND
    } handle_kind_t;

    typedef struct packed {
        cht_status_t          status;
        logic [INDEX_W-1:0]   index;
        logic                 side;
        logic [SLOT_W-1:0]    slot;
        logic [FLAG_W-1:0]    flags;
    } handle_result_t;

    // pool 0 holds descriptors, pool 1 the side entries (first SIDE_N used)
    handle_kind_t        pool_kind [2][DESC_N];
    logic [SLOT_W-1:0]   pool_slot [2][DESC_N];
    logic [FLAG_W-1:0]   desc_flags[DESC_N];
    handle_result_t      pending_results[$];
    int                  errors;
    int                  checks;
    int                  dry;
    int                  refused;

    // apply one request to the table copy and return its result
    function automatic handle_result_t serve_request(
        input logic [OP_W-1:0]    op,
        input logic               side,
        input logic [INDEX_W-1:0] idx,
        input logic [SLOT_W-1:0]  slot_in,
        input logic [FLAG_W-1:0]  flag_in
    );
        handle_result_t    r;
        int                pool_n;
        int                i;
        bit                found;
        logic [SLOT_W-1:0] slot;
        r = '0;
        r.status = STATUS_RANGE;
        pool_n = side ? SIDE_N : DESC_N;
        slot = slot_in & SLOT_MASK;
        found = 1'b0;
        case (op)
            OP_ALLOC: begin
                // descriptor 0 is never handed out by a plain allocate
                r.status = STATUS_NONE_FREE;
                for (i = side ? 0 : 1; i < pool_n && !found; i++) begin
                    if (pool_kind[side][i] == KIND_FREE) begin
                        found = 1'b1;
                        pool_kind[side][i] = KIND_RESERVED;
                        pool_slot[side][i] = '0;
                        r.status = STATUS_DONE;
                        r.index = INDEX_W'(i);
                        r.side = side;
                    end
                end
            end
            OP_ALLOC_FROM: begin
                // always the descriptor pool; the found entry loses its flags
                if (idx < DESC_N) begin
                    r.status = STATUS_NONE_FREE;
                    for (i = int'(idx); i < DESC_N && !found; i++) begin
                        if (pool_kind[0][i] == KIND_FREE) begin
                            found = 1'b1;
                            pool_kind[0][i] = KIND_RESERVED;
                            pool_slot[0][i] = '0;
                            desc_flags[i] = '0;
                            r.status = STATUS_DONE;
                            r.index = INDEX_W'(i);
                        end
                    end
                end
            end
            OP_BIND: begin
                if (idx < pool_n) begin
                    pool_kind[side][idx] = (slot != '0) ? KIND_BOUND : KIND_FREE;
                    pool_slot[side][idx] = slot;
                    r.status = STATUS_DONE;
                end
            end
            OP_LOOKUP: begin
                if (idx < pool_n) begin
                    if (pool_kind[side][idx] == KIND_BOUND)
                        r.slot = pool_slot[side][idx];
                    r.status = STATUS_DONE;
                end
            end
            OP_GET_FLAGS: begin
                if (!side && idx < DESC_N) begin
                    r.flags = desc_flags[idx];
                    r.status = STATUS_DONE;
                end
            end
            OP_SET_FLAGS: begin
                if (!side && idx < DESC_N) begin
                    desc_flags[idx] = flag_in;
                    r.status = STATUS_DONE;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // watch both channels; results are retired before new requests are predicted
    always @(posedge clk or negedge rst_n)
    begin : watch
        handle_result_t got;
        handle_result_t want;
        if (!rst_n)
        begin
            for (int p = 0; p < 2; p++)
                for (int i = 0; i < DESC_N; i++)
                begin
                    pool_kind[p][i] = KIND_FREE;
                    pool_slot[p][i] = '0;
                end
            for (int i = 0; i < DESC_N; i++)
                desc_flags[i] = '0;
            pending_results.delete();
            errors = 0;
            checks = 0;
            dry = 0;
            refused = 0;
        end
        else
        begin
            // result beat
            if (m_tvalid && m_tready)
            begin
                got.status = cht_status_t'(m_tuser[STATUS_W-1:0]);
                got.side   = m_tuser[STATUS_W];
                got.index  = m_tdata[INDEX_W-1:0];
                got.slot   = m_tdata[SLOT_LSB +: SLOT_W];
                got.flags  = m_tdata[FLAG_LSB +: FLAG_W];
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result beat with no request waiting: status %0d index %0d",
                             $time, got.status, got.index);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    checks++;
                    if (got.status !== want.status || got.index !== want.index ||
                        got.side !== want.side || got.slot !== want.slot ||
                        got.flags !== want.flags)
                    begin
                        $display("%0t: result mismatch", $time);
                        $display("    expected status %0d index %0d side %0d slot %h flags %h",
                                 want.status, want.index, want.side, want.slot, want.flags);
                        $display("    actual   status %0d index %0d side %0d slot %h flags %h",
                                 got.status, got.index, got.side, got.slot, got.flags);
                        errors++;
                    end
                end
            end
            // request beat
            if (s_tvalid && s_tready)
            begin
                want = serve_request(s_tuser[OP_W-1:0], s_tuser[OP_W],
                                     s_tdata[INDEX_W-1:0], s_tdata[SLOT_LSB +: SLOT_W],
                                     s_tdata[FLAG_LSB +: FLAG_W]);
                if (want.status == STATUS_NONE_FREE)
                    dry++;
                if (want.status == STATUS_RANGE)
                    refused++;
                pending_results.push_back(want);
            end
        end
        fail_count    <= errors;
        outstanding   <= pending_results.size();
        compared      <= checks;
        dry_count     <= dry;
        refused_count <= refused;
    end

endmodule

### test/tb.sv
// testbench top for the connection handle table: stimulus, output stalls and verdict
module tb import cht_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DESC_N      = DESCRIPTOR_COUNT_DEF;
    localparam int SIDE_N      = SIDE_COUNT_DEF;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;
    localparam int SLOT_LSB    = INDEX_W;
    localparam int FLAG_LSB    = INDEX_W + SLOT_W;

    // op codes with no meaning in the block
    localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata;   // entry_index, slot_number, flag_word
    logic [IN_USER_W-1:0]  s_tuser;   // op, side_pool
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DATA_W-1:0]     m_tdata;   // handle_index, slot_out, flags_out
    logic [OUT_USER_W-1:0] m_tuser;   // status, handle_side

    int fail_count;
    int outstanding;
    int compared;
    int dry_count;
    int refused_count;
    int send_idle;
    int recv_idle;
    int hold_left;
    int requests_sent;

    connection_handle_table_top #(
        .DESCRIPTOR_COUNT (DESCRIPTOR_COUNT_DEF),
        .SIDE_COUNT       (SIDE_COUNT_DEF),
        .SLOT_BITS        (SLOT_BITS_DEF)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    connection_handle_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .compared      (compared),
        .dry_count     (dry_count),
        .refused_count (refused_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("tb: errors");
        $finish;
    end

    // output side: random stalls, or a long hold-off while hold_left runs down
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // offer one request beat and wait for it to be taken; valid stays high after
    task automatic send_request(
        input logic [OP_W-1:0]    op,
        input logic               side,
        input logic [INDEX_W-1:0] idx,
        input logic [SLOT_W-1:0]  slot,
        input logic [FLAG_W-1:0]  flags
    );
        logic [DATA_W-1:0] beat;
        beat = '0;
        beat[INDEX_W-1:0]        = idx;
        beat[SLOT_LSB +: SLOT_W] = slot;
        beat[FLAG_LSB +: FLAG_W] = flags;
        if ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {side, op};
        s_tdata  <= beat;
        do
            @(posedge clk);
        while (!s_tready);
        requests_sent++;
    endtask

    // stop offering until every predicted result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // index mostly inside the pool, sometimes at its edges or anywhere in 16 bits
    function automatic logic [INDEX_W-1:0] pick_index(input int pool_n);
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return INDEX_W'($urandom_range(16'hFFFF));
        if (r < 10)
            return INDEX_W'(pool_n);
        if (r < 12)
            return INDEX_W'(pool_n - 1);
        if (r < 14)
            return '0;
        return INDEX_W'($urandom_range(pool_n - 1));
    endfunction

    function automatic logic [SLOT_W-1:0] pick_slot();
        if ($urandom_range(99) < 25)
            return '0;
        return SLOT_W'($urandom_range(12'hFFF));
    endfunction

    // one unrelated request of any kind
    task automatic send_any_request();
        logic [OP_W-1:0] op;
        logic            side;
        int              r;
        int              pool_n;
        r = $urandom_range(99);
        side = 1'($urandom_range(1));
        if (r < 22)
            op = OP_ALLOC;
        else if (r < 32)
            op = OP_ALLOC_FROM;
        else if (r < 52)
            op = OP_BIND;
        else if (r < 67)
            op = OP_LOOKUP;
        else if (r < 79)
            op = OP_GET_FLAGS;
        else if (r < 93)
            op = OP_SET_FLAGS;
        else
            op = $urandom_range(1) ? OP_UNDEF_HI : OP_UNDEF_LO;
        // flag ops on the side pool are refused, keep them rare
        if (op == OP_GET_FLAGS || op == OP_SET_FLAGS)
            side = ($urandom_range(99) < 15);
        pool_n = (side && op != OP_ALLOC_FROM) ? SIDE_N : DESC_N;
        send_request(op, side, pick_index(pool_n), pick_slot(), $urandom);
    endtask

    // random traffic: allocation bursts, free sweeps, bind and flag pairs, loose requests
    task automatic run_random(input int count);
        int              done_n;
        int              r;
        int              len;
        int              start;
        int              pool_n;
        logic            side;
        logic [INDEX_W-1:0] idx;
        done_n = 0;
        while (done_n < count)
        begin
            r = $urandom_range(99);
            side = 1'($urandom_range(1));
            pool_n = side ? SIDE_N : DESC_N;
            if (r < 15)
            begin
                // allocate until the pool may run dry
                len = side ? $urandom_range(1, 36) : $urandom_range(1, 70);
                for (int k = 0; k < len; k++)
                    send_request(OP_ALLOC, side, INDEX_W'($urandom_range(16'hFFFF)),
                                 pick_slot(), $urandom);
                done_n += len;
            end
            else if (r < 25)
            begin
                // free a run of entries
                start = $urandom_range(pool_n - 1);
                len = $urandom_range(1, 16);
                for (int k = 0; k < len && start + k < pool_n; k++)
                begin
                    send_request(OP_BIND, side, INDEX_W'(start + k), '0, $urandom);
                    done_n++;
                end
            end
            else if (r < 35)
            begin
                // bind then look up the same entry
                idx = pick_index(pool_n);
                send_request(OP_BIND, side, idx, pick_slot(), $urandom);
                send_request(OP_LOOKUP, side, idx, SLOT_W'($urandom_range(12'hFFF)),
                             $urandom);
                done_n += 2;
            end
            else if (r < 45)
            begin
                // write then read back a descriptor flag word
                idx = pick_index(DESC_N);
                send_request(OP_SET_FLAGS, 1'b0, idx, pick_slot(), $urandom);
                send_request(OP_GET_FLAGS, 1'b0, idx, pick_slot(), $urandom);
                done_n += 2;
            end
            else
            begin
                send_any_request();
                done_n++;
            end
        end
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        send_idle = 36;
        recv_idle = 57;
        hold_left = 0;
        requests_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: first allocations, flag handling, range and pool errors, binds, lookups, undefined ops
        send_request(OP_LOOKUP,     1'b0, 16'd0,      12'h000, 32'h0);
        send_request(OP_ALLOC,      1'b0, 16'd0,      12'h000, 32'h0);
        send_request(OP_ALLOC,      1'b1, 16'd0,      12'h000, 32'h0);
        send_request(OP_ALLOC_FROM, 1'b1, 16'd0,      12'h000, 32'h0);
        send_request(OP_SET_FLAGS,  1'b0, 16'd63,     12'h000, 32'hFFFF_FFFF);
        send_request(OP_GET_FLAGS,  1'b0, 16'd63,     12'h000, 32'h0);
        send_request(OP_ALLOC_FROM, 1'b0, 16'd63,     12'h000, 32'h0);
        send_request(OP_GET_FLAGS,  1'b0, 16'd63,     12'h000, 32'h0);
        send_request(OP_SET_FLAGS,  1'b0, 16'd1,      12'h000, 32'h5A5A_A5A5);
        send_request(OP_ALLOC_FROM, 1'b0, 16'd64,     12'h000, 32'h0);
        send_request(OP_ALLOC_FROM, 1'b0, 16'hFFFF,   12'h000, 32'h0);
        send_request(OP_GET_FLAGS,  1'b1, 16'd0,      12'h000, 32'h0);
        send_request(OP_SET_FLAGS,  1'b1, 16'd0,      12'h000, 32'hAAAA_5555);
        send_request(OP_SET_FLAGS,  1'b0, 16'd64,     12'h000, 32'h1234_5678);
        send_request(OP_BIND,       1'b0, 16'd0,      12'hFFF, 32'h0);
        send_request(OP_LOOKUP,     1'b0, 16'd0,      12'h000, 32'h0);
        send_request(OP_BIND,       1'b1, 16'd31,     12'h001, 32'h0);
        send_request(OP_LOOKUP,     1'b1, 16'd31,     12'h000, 32'h0);
        send_request(OP_BIND,       1'b1, 16'd32,     12'h005, 32'h0);
        send_request(OP_LOOKUP,     1'b0, 16'hFFFF,   12'h000, 32'h0);
        send_request(OP_LOOKUP,     1'b0, 16'd1,      12'h000, 32'h0);
        send_request(OP_BIND,       1'b0, 16'd0,      12'h000, 32'h0);
        send_request(OP_LOOKUP,     1'b0, 16'd0,      12'h000, 32'h0);
        send_request(OP_UNDEF_LO,   1'b0, 16'd2,      12'h003, 32'h0);
        send_request(OP_UNDEF_HI,   1'b1, 16'd2,      12'h003, 32'h0);

        // sender idles less than receiver, with one long output hold-off
        run_random(130);
        hold_left = HOLD_CYCLES;
        run_random(130);
        drain_results();

        // receiver idles less than sender
        send_idle = 57;
        recv_idle = 36;
        run_random(270);
        drain_results();

        // no idling; a second hold-off with the input kept busy
        send_idle = 0;
        recv_idle = 0;
        run_random(120);
        hold_left = HOLD_CYCLES;
        run_random(130);
        drain_results();

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("tb: %0d requests over three stall mixes and two long output hold-offs",
                 requests_sent);
        $display("tb: %0d results compared, %0d found no free entry, %0d refused",
                 compared, dry_count, refused_count);
        if (fail_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
